[src/pwp_pkg.sv]
// Shared constants, types and helpers for the passwd entry field parser.
package pwp_pkg;

  // Longest line in bytes; offsets at or past this reject the line
  localparam int unsigned MAX_LINE = 4096;
  // Width of a uid/gid value
  localparam int unsigned ID_BITS = 32;
  // Byte offset counter width; it must hold MAX_LINE itself (saturation)
  localparam int unsigned POS_W = $clog2(MAX_LINE + 1);
  // Accumulator width for one times-ten step plus a digit
  localparam int unsigned MAC_W = ID_BITS + 4;

  // Output field widths
  localparam int unsigned IDX_W = 3;
  localparam int unsigned OFS_W = 12;

  // Field indices of uid, gid, home and shell, and the index one past the last field (the field count)
  localparam logic [IDX_W-1:0] FIELD_UID   = 3'd2;
  localparam logic [IDX_W-1:0] FIELD_GID   = 3'd3;
  localparam logic [IDX_W-1:0] FIELD_HOME  = 3'd5;
  localparam logic [IDX_W-1:0] FIELD_SHELL = 3'd6;
  localparam logic [IDX_W-1:0] FIELD_PAST  = 3'd7;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Line phase codes
  localparam logic [1:0] PH_LEAD   = 2'd0;
  localparam logic [1:0] PH_FIELDS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  // Number phase codes for uid/gid fields
  localparam logic [2:0] NP_EMPTY  = 3'd0;
  localparam logic [2:0] NP_WS     = 3'd1;
  localparam logic [2:0] NP_SIGN   = 3'd2;
  localparam logic [2:0] NP_DIGITS = 3'd3;
  localparam logic [2:0] NP_BAD    = 3'd4;

  // Control from the line parser to the number parser
  typedef struct packed {
    logic feed;   // apply the byte to the number
    logic clear;  // open a fresh field after this step
  } num_ctl_t;

  // Verdict of the number parser on the field as it stands after this byte
  typedef struct packed {
    logic               ok;
    logic [ID_BITS-1:0] value;
  } num_stat_t;

  // One result item
  typedef struct packed {
    logic [IDX_W-1:0]   field_index;
    logic [OFS_W-1:0]   field_start;
    logic [OFS_W-1:0]   field_length;
    logic [ID_BITS-1:0] id_value;
    logic               field_ok;
    logic               line_done;
    logic               accepted;
  } res_t;

  // Space, tab, LF, VT, FF, CR
  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

[src/pwp_num.sv]
// Decimal uid/gid field parser: sign, digits and times-ten accumulate.
module pwp_num
  import pwp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  num_ctl_t  ctl_i,
  input  logic [7:0] byte_i,
  output num_stat_t stat_o
);

  logic [2:0]         np_q, np_d, np_f;
  logic [ID_BITS-1:0] acc_q, acc_d, acc_f;
  logic               ovf_q, ovf_d, ovf_f;
  logic               minus_q, minus_d, minus_f;
  logic               early;
  logic [MAC_W-1:0]   mac;

  // acc * 10 + digit, overflow when any bit lands above ID_BITS
  assign mac = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
             + MAC_W'(byte_i - CH_ZERO);

  // Field state after this byte
  always_comb begin
    np_f    = np_q;
    acc_f   = acc_q;
    ovf_f   = ovf_q;
    minus_f = minus_q;
    early   = (np_q == NP_EMPTY) || (np_q == NP_WS);
    if (ctl_i.feed) begin
      if (is_ws(byte_i)) begin
        np_f = early ? NP_WS : NP_BAD;
      end else if ((byte_i == CH_PLUS) || (byte_i == CH_MINUS)) begin
        if (early) begin
          np_f    = NP_SIGN;
          minus_f = (byte_i == CH_MINUS);
        end else begin
          np_f = NP_BAD;
        end
      end else if ((byte_i >= CH_ZERO) && (byte_i <= CH_NINE) && (np_q != NP_BAD)) begin
        np_f = NP_DIGITS;
        if (!ovf_q) begin
          if (mac[MAC_W-1:ID_BITS] != '0) begin
            ovf_f = 1'b1;
          end else begin
            acc_f = mac[ID_BITS-1:0];
          end
        end
      end else begin
        np_f = NP_BAD;
      end
    end
  end

  // Well formed: empty, or digits without overflow and no negative value
  always_comb begin
    stat_o.ok    = (np_f == NP_EMPTY) ||
                   ((np_f == NP_DIGITS) && !ovf_f && !(minus_f && (acc_f != '0)));
    stat_o.value = stat_o.ok ? acc_f : '0;
  end

  // Next register values; opening a field clears everything
  always_comb begin
    np_d    = np_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    minus_d = minus_q;
    if (step_i) begin
      if (ctl_i.clear) begin
        np_d    = NP_EMPTY;
        acc_d   = '0;
        ovf_d   = 1'b0;
        minus_d = 1'b0;
      end else begin
        np_d    = np_f;
        acc_d   = acc_f;
        ovf_d   = ovf_f;
        minus_d = minus_f;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_q    <= NP_EMPTY;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      minus_q <= 1'b0;
    end else begin
      np_q    <= np_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      minus_q <= minus_d;
    end
  end

endmodule

[src/pwp_line.sv]
// Line state: leading whitespace, field splitting at colons, result forming.
module pwp_line
  import pwp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  logic [1:0]       phase_q, phase_d;
  logic [IDX_W-1:0] fc_q, fc_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] start_q, start_d;
  logic             rej_q, rej_d;

  logic [1:0]       ph;
  logic [POS_W-1:0] start_eff;
  logic [POS_W-1:0] end_pos;
  logic [POS_W-1:0] flen;
  logic             is_id;
  logic             do_close;
  logic             rej;
  num_ctl_t         nctl;
  num_stat_t        nstat;

  pwp_num u_num (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step_i),
    .ctl_i  (nctl),
    .byte_i (byte_i),
    .stat_o (nstat)
  );

  assign is_id = (fc_q == FIELD_UID) || (fc_q == FIELD_GID);
  assign flen  = end_pos - start_eff;

  // One byte of the line
  always_comb begin
    phase_d     = phase_q;
    fc_d        = fc_q;
    start_d     = start_q;
    pos_d       = (pos_q < POS_W'(MAX_LINE)) ? pos_q + 1'b1 : pos_q;
    nctl.feed   = 1'b0;
    nctl.clear  = 1'b0;
    ph          = phase_q;
    rej         = rej_q;
    start_eff   = start_q;
    end_pos     = pos_q;
    do_close    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    // overlong line
    if ((ph != PH_DONE) && (pos_q >= POS_W'(MAX_LINE))) begin
      rej = 1'b1;
      ph  = PH_DONE;
    end

    // leading whitespace, comment or empty line
    if (ph == PH_LEAD) begin
      if ((byte_i == CH_NUL) || (byte_i == CH_HASH)) begin
        rej = 1'b1;
        ph  = PH_DONE;
      end else if (!is_ws(byte_i)) begin
        ph         = PH_FIELDS;
        start_eff  = pos_q;
        start_d    = pos_q;
        nctl.clear = 1'b1;
      end
    end

    if (ph == PH_FIELDS) begin
      if (byte_i == CH_COLON) begin
        do_close    = 1'b1;
        res_valid_o = 1'b1;
        if (is_id && !nstat.ok) rej = 1'b1;
        if (fc_q >= FIELD_SHELL) begin
          fc_d = FIELD_PAST;
          ph   = PH_DONE;
        end else begin
          fc_d       = fc_q + 1'b1;
          start_d    = pos_q + 1'b1;
          nctl.clear = 1'b1;
        end
        res_o.line_done = last_i;
        res_o.accepted  = last_i && !rej && (fc_q >= FIELD_HOME);
      end else if (byte_i == CH_NUL) begin
        do_close    = 1'b1;
        res_valid_o = 1'b1;
        if (is_id && !nstat.ok) rej = 1'b1;
        if (fc_q != FIELD_SHELL) rej = 1'b1;
        ph = PH_DONE;
        res_o.line_done = last_i;
        res_o.accepted  = last_i && !rej;
      end else begin
        nctl.feed = is_id;
        if (last_i) begin
          do_close    = 1'b1;
          res_valid_o = 1'b1;
          end_pos     = pos_q + 1'b1;
          if (is_id && !nstat.ok) rej = 1'b1;
          if (fc_q != FIELD_SHELL) rej = 1'b1;
          res_o.line_done = 1'b1;
          res_o.accepted  = !rej;
        end
      end
    end

    // field close payload
    if (do_close) begin
      res_o.field_index  = fc_q;
      res_o.field_start  = start_eff[OFS_W-1:0];
      res_o.field_length = flen[OFS_W-1:0];
      res_o.id_value     = is_id ? nstat.value : '0;
      res_o.field_ok     = is_id ? nstat.ok : 1'b1;
    end

    phase_d = ph;
    rej_d   = rej;

    // line end: report if nothing closed, then return to reset state
    if (last_i) begin
      if (!res_valid_o) begin
        res_valid_o     = 1'b1;
        res_o           = '0;
        res_o.line_done = 1'b1;
        res_o.accepted  = (ph == PH_DONE) && !rej;
      end
      phase_d    = PH_LEAD;
      fc_d       = '0;
      pos_d      = '0;
      start_d    = '0;
      rej_d      = 1'b0;
      nctl.clear = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      fc_q    <= '0;
      pos_q   <= '0;
      start_q <= '0;
      rej_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      fc_q    <= fc_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      rej_q   <= rej_d;
    end
  end

endmodule

[src/passwd_entry_field_parser_unit.sv]
// Top level of the passwd entry field parser: stream ports and pipeline registers.
//
// Takes one byte of a passwd line per transfer (tlast on the line's final byte)
// and sends one transfer for each closed field, carrying its index, offset,
// length, parsed uid/gid value and a well-formed flag; the transfer for the
// line's final byte has tlast set and reports whether the whole line was
// accepted (a line with no field closed on its final byte still gets one
// such transfer). A byte can be taken every clock cycle; each byte passes
// through an input register and then a result register on its way to the
// output. Back-pressure on the result side stalls the input side only when
// both registers are full.
module passwd_entry_field_parser_unit
  import pwp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] field_index, [14:3] field_start, [26:15] field_length,
  // [58:27] id_value, [59] field_ok, [60] accepted, [63:61] zero
  output logic [63:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o    // line_done
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q, out_valid_d;
  res_t       res_q;
  logic       advance;
  logic       res_valid;
  res_t       res;

  // The input stage moves on whenever the result register can take its output
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  pwp_line u_line (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .last_i      (in_last_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res_valid;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = res_q.line_done;
  assign m_axis_tdata_o  = {3'b000, res_q.accepted, res_q.field_ok, res_q.id_value,
                            res_q.field_length, res_q.field_start, res_q.field_index};

endmodule
